// File: design/cheb_pkg.sv
// Shared widths, constants and helpers for the Chebyshev evaluator.
`timescale 1ns / 1ps

package cheb_pkg;

    localparam int DEG_W        = 6;
    localparam int X_W          = 32;
    localparam int T_W          = 32;
    localparam int U_W          = 37;
    localparam int D1_W         = 42;
    localparam int D2_W         = 50;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 168;
    localparam int FRAC_W       = 30;
    localparam int OP_W         = 52;
    localparam int SLICE_W      = 26;
    localparam int MA_W         = 33;
    localparam int MB_W         = SLICE_W + 1;
    localparam int PROD_W       = MA_W + MB_W;
    localparam int ACC_W        = PROD_W + SLICE_W;
    localparam int DEF_MAX_DEGREE = 32;

    localparam logic signed [OP_W-1:0] ONE_Q30 = OP_W'(longint'(1) << FRAC_W);

    typedef enum logic [1:0] {
        OP_D1,
        OP_T,
        OP_U,
        OP_D2
    } mul_op_t;

    function automatic logic signed [OP_W-1:0] clamp_abs(
        input logic signed [OP_W-1:0] v,
        input logic signed [OP_W-1:0] lim
    );
        logic signed [OP_W-1:0] r;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        else
            r = v;
        return r;
    endfunction

endpackage

// File: design/chebyshev_poly_and_derivatives_core.sv
// Top level: Chebyshev Tn, Un, dTn/dx and d2Tn/dx2 evaluator with one shared multiplier.
`timescale 1ns / 1ps

// Evaluates Tn(x), Un(x), Tn'(x) and Tn''(x) in Q.30 for a degree n and a point x in Q1.30,
// using the three-term recurrences on one 33x27 signed multiplier that is stepped by a small
// sequencer. Each product with a 52-bit operand is formed from its low and high slice in turn.
// Each recurrence step needs four products, and the final n*U(n-1) needs one more; for n = 0
// the multiplier is not used and the result is loaded directly.
// One item is worked on at a time; s_axis_tready is high only while idle. A finished result
// is held in the output register until the transfer on the master side completes, and the
// next item may be taken while it waits. Degrees above MAX_DEGREE and points outside
// [-1, +1] are saturated.
module chebyshev_poly_and_derivatives_core
    import cheb_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [5:0] degree, [37:6] x_value, [39:38] zero
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [31:0] first_kind, [68:32] second_kind, [110:69] first_derivative,
    // [160:111] second_derivative, [167:161] zero
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam logic signed [OP_W-1:0] T_LIM  = ONE_Q30;
    localparam logic signed [OP_W-1:0] U_LIM  =
        OP_W'(longint'(MAX_DEGREE + 1) * (longint'(1) << FRAC_W));
    localparam logic signed [OP_W-1:0] D1_LIM =
        OP_W'(longint'(MAX_DEGREE * MAX_DEGREE) * (longint'(1) << FRAC_W));
    localparam logic signed [OP_W-1:0] D2_LIM =
        OP_W'(longint'(MAX_DEGREE * MAX_DEGREE * (MAX_DEGREE * MAX_DEGREE - 1) / 3)
              * (longint'(1) << FRAC_W));

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_LOAD
    } state_t;

    state_t                   state_reg;
    mul_op_t                  op_reg;
    logic                     slice_reg;
    logic [DEG_W-1:0]         n_reg;
    logic [DEG_W-1:0]         k_reg;
    logic signed [MA_W-1:0]   x2_reg;
    logic signed [OP_W-1:0]   t_prev_reg, t_cur_reg;
    logic signed [OP_W-1:0]   u_prev_reg, u_cur_reg;
    logic signed [OP_W-1:0]   d2_prev_reg, d2_cur_reg;
    logic signed [OP_W-1:0]   d1_reg, tm_reg, um_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;

    logic [DEG_W-1:0]         deg_in, n_sat;
    logic signed [X_W-1:0]    x_in, x_sat;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [OP_W-1:0]   mul_v;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  sum;
    logic signed [OP_W-1:0]   res;
    logic signed [OP_W-1:0]   t_next, u_next, d2_next;
    logic signed [OP_W-1:0]   t_o, u_o, d1_o, d2_o;

    assign deg_in = s_axis_tdata[DEG_W-1:0];
    assign x_in   = s_axis_tdata[DEG_W +: X_W];
    assign n_sat  = (deg_in > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_in;

    always_comb
    begin
        if (x_in > X_W'(ONE_Q30))
            x_sat = X_W'(ONE_Q30);
        else if (x_in < -X_W'(ONE_Q30))
            x_sat = -X_W'(ONE_Q30);
        else
            x_sat = x_in;
    end

    always_comb
    begin
        case (op_reg)
            OP_D1:   mul_v = u_prev_reg;
            OP_T:    mul_v = t_cur_reg;
            OP_U:    mul_v = u_cur_reg;
            OP_D2:   mul_v = d2_cur_reg;
            default: mul_v = t_cur_reg;
        endcase
    end

    assign mul_a = (op_reg == OP_D1) ? $signed({{(MA_W - DEG_W){1'b0}}, k_reg}) : x2_reg;
    assign mul_b = slice_reg ? $signed({mul_v[OP_W-1], mul_v[OP_W-1:SLICE_W]})
                             : $signed({1'b0, mul_v[SLICE_W-1:0]});
    assign prod  = mul_a * mul_b;
    assign sum   = acc_reg + $signed({prod, {SLICE_W{1'b0}}});
    assign res   = (op_reg == OP_D1) ? sum[OP_W-1:0] : sum[FRAC_W +: OP_W];

    assign t_next  = tm_reg - t_prev_reg;
    assign u_next  = um_reg - u_prev_reg;
    assign d2_next = (d1_reg <<< 2) + res - d2_prev_reg;

    assign t_o  = clamp_abs(t_cur_reg, T_LIM);
    assign u_o  = clamp_abs(u_cur_reg, U_LIM);
    assign d1_o = clamp_abs(d1_reg, D1_LIM);
    assign d2_o = clamp_abs(d2_cur_reg, D2_LIM);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_D1;
            slice_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && state_reg != S_LOAD)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg    <= OP_D1;
                        slice_reg <= 1'b0;
                        if (n_sat == '0)
                            state_reg <= S_LOAD;
                        else
                            state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    slice_reg <= ~slice_reg;
                    if (slice_reg)
                    begin
                        case (op_reg)
                            OP_D1:
                            begin
                                if (k_reg == n_reg)
                                    state_reg <= S_LOAD;
                                else
                                    op_reg <= OP_T;
                            end
                            OP_T:    op_reg <= OP_U;
                            OP_U:    op_reg <= OP_D2;
                            OP_D2:   op_reg <= OP_D1;
                            default: op_reg <= OP_D1;
                        endcase
                    end
                end
                S_LOAD:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {7'b0, d2_o[D2_W-1:0], d1_o[D1_W-1:0],
                                          u_o[U_W-1:0], t_o[T_W-1:0]};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            n_reg       <= n_sat;
            k_reg       <= DEG_W'(1);
            x2_reg      <= {x_sat, 1'b0};
            d2_prev_reg <= '0;
            d2_cur_reg  <= '0;
            d1_reg      <= '0;
            if (n_sat == '0)
            begin
                t_cur_reg <= ONE_Q30;
                u_cur_reg <= ONE_Q30;
            end
            else
            begin
                t_prev_reg <= ONE_Q30;
                t_cur_reg  <= OP_W'(x_sat);
                u_prev_reg <= ONE_Q30;
                u_cur_reg  <= OP_W'($signed({x_sat, 1'b0}));
            end
        end
        else if (state_reg == S_MUL)
        begin
            if (!slice_reg)
                acc_reg <= ACC_W'(prod);
            else
            begin
                case (op_reg)
                    OP_D1: d1_reg <= res;
                    OP_T:  tm_reg <= res;
                    OP_U:  um_reg <= res;
                    OP_D2:
                    begin
                        t_prev_reg  <= t_cur_reg;
                        t_cur_reg   <= t_next;
                        u_prev_reg  <= u_cur_reg;
                        u_cur_reg   <= u_next;
                        d2_prev_reg <= d2_cur_reg;
                        d2_cur_reg  <= d2_next;
                        k_reg       <= k_reg + DEG_W'(1);
                    end
                    default: d1_reg <= res;
                endcase
            end
        end
    end

endmodule
